@@ src/pot_pkg.sv @@
// pot_pkg: shared types and constants for the pointer owner table.
// Used by the interfaces, the compare cell and the top level.
`default_nettype none

package pot_pkg;

    localparam int ADDR_W           = 32;
    localparam int CORE_W           = 6;
    localparam int CAPACITY_DEFAULT = 64;

    typedef enum logic [1:0] {
        OP_INSERT        = 2'd0,
        OP_LOOKUP_OWNER  = 2'd1,
        OP_TEST_DANGLING = 2'd2,
        OP_QUERY_OTHER   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_SAME     = 3'd1,
        ST_IGNORED  = 3'd2,
        ST_CONFLICT = 3'd3,
        ST_FULL     = 3'd4,
        ST_MISSING  = 3'd5
    } status_t;

    // request as it travels down the cell chain
    typedef struct packed {
        logic                vld;
        op_t                 op;
        logic [ADDR_W-1:0]   addr;
        logic [CORE_W-1:0]   core;
        logic                dang;
        logic                hit;
        status_t             status;
        logic [CORE_W-1:0]   owner;
        logic                mark;
    } req_t;

endpackage

`default_nettype wire

@@ src/pot_if.sv @@
// pot_if: request, response and configuration channel interfaces.
// Depends on pot_pkg for field widths.
`default_nettype none

interface pot_req_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    operation;
    logic [pot_pkg::ADDR_W-1:0]    address;
    logic [pot_pkg::CORE_W-1:0]    core_id;
    logic                          is_dangling;

    modport source (output valid, operation, address, core_id, is_dangling, input ready);
    modport sink   (input valid, operation, address, core_id, is_dangling, output ready);
endinterface

interface pot_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [2:0]                    status;
    logic [pot_pkg::CORE_W-1:0]    owner_core;
    logic                          dangling_mark;
    logic                          other_core;

    modport source (output valid, status, owner_core, dangling_mark, other_core, input ready);
    modport sink   (input valid, status, owner_core, dangling_mark, other_core, output ready);
endinterface

interface pot_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [pot_pkg::CORE_W-1:0]    own_core_id;

    modport source (output valid, own_core_id, input ready);
    modport sink   (input valid, own_core_id, output ready);
endinterface

`default_nettype wire

@@ src/pot_cell.sv @@
// pot_cell: one table entry plus one chain stage of the request path.
// Depends on pot_pkg (req_t, op_t, status_t).
`default_nettype none

module pot_cell (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire pot_pkg::req_t req_i,
    output pot_pkg::req_t      req_o,
    output logic               occ
);

    logic                          vld_reg;
    logic [pot_pkg::ADDR_W-1:0]    key_reg;
    logic [pot_pkg::CORE_W-1:0]    owner_reg;
    logic                          mark_reg;
    pot_pkg::req_t                 req_reg;
    pot_pkg::req_t                 req_next;
    logic                          match;
    logic                          claim;

    always_comb
    begin
        match = req_i.vld && !req_i.hit && vld_reg && (key_reg == req_i.addr);
        claim = req_i.vld && !req_i.hit && !vld_reg && (req_i.op == pot_pkg::OP_INSERT);
        req_next = req_i;
        if (match)
        begin
            req_next.hit   = 1'b1;
            req_next.owner = owner_reg;
            req_next.mark  = mark_reg;
            if (req_i.op != pot_pkg::OP_INSERT)
                req_next.status = pot_pkg::ST_OK;
            else if (owner_reg == req_i.core)
                req_next.status = pot_pkg::ST_SAME;
            else if (mark_reg && !req_i.dang)
                req_next.status = pot_pkg::ST_IGNORED;
            else
                req_next.status = pot_pkg::ST_CONFLICT;
        end
        else if (claim)
        begin
            req_next.hit    = 1'b1;
            req_next.status = pot_pkg::ST_OK;
            req_next.owner  = req_i.core;
            req_next.mark   = req_i.dang;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
            req_reg <= '0;
        end
        else if (en)
        begin
            req_reg <= req_next;
            if (claim)
                vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && claim)
        begin
            key_reg   <= req_i.addr;
            owner_reg <= req_i.core;
            mark_reg  <= req_i.dang;
        end
    end

    assign req_o = req_reg;
    assign occ   = vld_reg;

endmodule

`default_nettype wire

@@ src/pointer_owner_table_unit.sv @@
// pointer_owner_table_unit: associative address-to-owner table built as a
// chain of compare cells. Depends on pot_pkg, pot_if.sv and pot_cell.
//
// Usage:
//   req  : valid/ready request channel (operation, address, core_id,
//          is_dangling). Insert appends or reports same/ignored/conflict/full;
//          the three lookups report owner, dangling mark and other-core flag.
//   rsp  : valid/ready response channel, one response per request, in order.
//   cfg  : valid/ready write of own_core_id, always ready; write while idle.
// Pipeline: one registered chain stage per table entry; a request passes
//   through every cell's register in order before its response is valid.
//   Throughput: one request per cycle while rsp is not stalled; each
//   request walks the cells in order behind the previous one, so it sees
//   every earlier insert.
// Reset: all entries invalid, own_core_id cleared, no request in flight.
// Stall: when rsp is valid and not ready the whole chain holds and
//   req.ready drops; no request is lost or repeated.
`default_nettype none

module pointer_owner_table_unit #(
    parameter int CAPACITY = pot_pkg::CAPACITY_DEFAULT
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    pot_cfg_if.sink     cfg,
    pot_req_if.sink     req,
    pot_rsp_if.source   rsp
);

    pot_pkg::req_t                 chain [CAPACITY+1];
    logic [CAPACITY-1:0]           occ;
    logic                          en;
    logic [pot_pkg::CORE_W-1:0]    own_core_reg;
    pot_pkg::req_t                 last;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            own_core_reg <= '0;
        else if (cfg.valid)
            own_core_reg <= cfg.own_core_id;
    end

    assign last      = chain[CAPACITY];
    assign en        = !last.vld || rsp.ready;
    assign req.ready = en;

    always_comb
    begin
        chain[0].vld    = req.valid;
        chain[0].op     = pot_pkg::op_t'(req.operation);
        chain[0].addr   = req.address;
        chain[0].core   = req.core_id;
        chain[0].dang   = req.is_dangling;
        chain[0].hit    = 1'b0;
        chain[0].status = pot_pkg::ST_OK;
        chain[0].owner  = '0;
        chain[0].mark   = 1'b0;
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        pot_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .req_i (chain[i]),
            .req_o (chain[i+1]),
            .occ   (occ[i])
        );
    end

    assign rsp.valid = last.vld;

    always_comb
    begin
        if (last.hit)
        begin
            rsp.status        = last.status;
            rsp.owner_core    = last.owner;
            rsp.dangling_mark = last.mark;
            rsp.other_core    = (last.op != pot_pkg::OP_INSERT) && (last.owner != own_core_reg);
        end
        else
        begin
            rsp.status        = (last.op == pot_pkg::OP_INSERT) ? pot_pkg::ST_FULL
                                                                : pot_pkg::ST_MISSING;
            rsp.owner_core    = '0;
            rsp.dangling_mark = 1'b0;
            rsp.other_core    = 1'b0;
        end
    end

    // occupied entries always form a prefix of the chain
    a_occ_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        ((occ >> 1) & ~occ) == '0)
        else $error("occupied cells not contiguous");

    // entries are never released
    a_occ_grow: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ((occ & $past(occ)) == $past(occ)))
        else $error("occupied cell was released");

    // full is reported only when every cell holds an entry
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status == pot_pkg::ST_FULL)) |-> (&occ))
        else $error("full reported with a free cell");

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
// testbench: self-checking bench for pointer_owner_table_unit.
// Needs pot_pkg and the channel interfaces from pot_if.sv; drives directed and random
// requests, predicts every response and compares it with the block's output.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pot_pkg::*;

    localparam int TABLE_DEPTH = CAPACITY_DEFAULT;
    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        status_t             status;
        logic [CORE_W-1:0]   owner;
        logic                mark;
        logic                other;
    } owner_reply_t;

    typedef struct {
        op_t                 op;
        logic [ADDR_W-1:0]   addr;
        logic [CORE_W-1:0]   core;
        logic                dang;
        bit                  typed;
        owner_reply_t        want;
    } table_row_t;

    logic clk = 1'b0;
    logic rst_n;

    pot_cfg_if cfg_ch ();
    pot_req_if req_ch ();
    pot_rsp_if rsp_ch ();

    pointer_owner_table_unit uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #1 clk = ~clk;

    // predicted table contents
    logic [ADDR_W-1:0]   tbl_addr  [TABLE_DEPTH];
    logic [CORE_W-1:0]   tbl_owner [TABLE_DEPTH];
    logic                tbl_dang  [TABLE_DEPTH];
    int                  entry_cnt;
    logic [CORE_W-1:0]   own_id;

    owner_reply_t        owed_replies [$];
    table_row_t          directed_rows [$];
    int                  errors;
    int                  quiet_cycles;
    bit                  req_idle_on;
    bit                  rsp_idle_on;
    int                  rsp_hold_len;

    task automatic report_mismatch(string msg);
        errors++;
        $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    // applies one request to the predicted table and returns the response it yields
    function automatic owner_reply_t apply_to_table(op_t op, logic [ADDR_W-1:0] addr,
                                                    logic [CORE_W-1:0] core, logic dang);
        owner_reply_t r;
        int hit;
        r = '{ST_MISSING, '0, 1'b0, 1'b0};
        hit = -1;
        for (int i = 0; i < entry_cnt; i++)
        begin
            if (hit < 0 && tbl_addr[i] == addr)
                hit = i;
        end
        if (op == OP_INSERT)
        begin
            if (hit >= 0)
            begin
                r.owner = tbl_owner[hit];
                r.mark  = tbl_dang[hit];
                if (tbl_owner[hit] == core)
                    r.status = ST_SAME;
                else if (tbl_dang[hit] && !dang)
                    r.status = ST_IGNORED;
                else
                    r.status = ST_CONFLICT;
            end
            else if (entry_cnt >= TABLE_DEPTH)
                r.status = ST_FULL;
            else
            begin
                tbl_addr[entry_cnt]  = addr;
                tbl_owner[entry_cnt] = core;
                tbl_dang[entry_cnt]  = dang;
                entry_cnt++;
                r = '{ST_OK, core, dang, 1'b0};
            end
        end
        else if (hit >= 0)
            r = '{ST_OK, tbl_owner[hit], tbl_dang[hit], tbl_owner[hit] != own_id};
        return r;
    endfunction

    function automatic void add_row(op_t op, logic [ADDR_W-1:0] addr, logic [CORE_W-1:0] core,
                                    logic dang, bit typed, owner_reply_t want);
        table_row_t row;
        row = '{op, addr, core, dang, typed, want};
        directed_rows.push_back(row);
    endfunction

    // called at a rising edge; returns at the edge where the request is taken
    task automatic send_request(op_t op, logic [ADDR_W-1:0] addr, logic [CORE_W-1:0] core,
                                logic dang, bit typed, owner_reply_t want);
        int gap;
        owner_reply_t predicted;
        gap = req_idle_on ? $urandom_range(0, 11) : 0;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.operation   <= op;
        req_ch.address     <= addr;
        req_ch.core_id     <= core;
        req_ch.is_dangling <= dang;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
        predicted = apply_to_table(op, addr, core, dang);
        owed_replies.push_back(typed ? want : predicted);
    endtask

    task automatic random_request();
        op_t op;
        logic [ADDR_W-1:0] addr;
        logic [CORE_W-1:0] core;
        int k;
        op = ($urandom_range(0, 9) < 4) ? OP_INSERT : op_t'($urandom_range(1, 3));
        k = -1;
        if (entry_cnt > 0 && $urandom_range(0, 9) < 6)
        begin
            k = $urandom_range(0, entry_cnt - 1);
            addr = tbl_addr[k];
        end
        else
            addr = $urandom;
        case ($urandom_range(0, 4))
            0: core = own_id;
            1: core = (k >= 0) ? tbl_owner[k] : '0;
            2: core = '0;
            3: core = '1;
            default: core = CORE_W'($urandom);
        endcase
        send_request(op, addr, core, 1'($urandom_range(0, 1)), 1'b0, owner_reply_t'(0));
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (owed_replies.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_own_core(logic [CORE_W-1:0] id);
        cfg_ch.valid       <= 1'b1;
        cfg_ch.own_core_id <= id;
        do @(posedge clk); while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
        own_id = id;
    endtask

    // response side
    initial
    begin : rsp_side
        int gap;
        int hold;
        forever
        begin
            if (rsp_hold_len > 0)
            begin
                hold = rsp_hold_len;
                rsp_hold_len = 0;
                rsp_ch.ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            gap = rsp_idle_on ? $urandom_range(0, 11) : 0;
            if (gap > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (!(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1));
        end
    end

    always @(posedge clk)
    begin : check_rsp
        owner_reply_t want;
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (owed_replies.size() == 0)
                report_mismatch("response with no request outstanding");
            else
            begin
                want = owed_replies.pop_front();
                if (rsp_ch.status !== want.status || rsp_ch.owner_core !== want.owner
                    || rsp_ch.dangling_mark !== want.mark || rsp_ch.other_core !== want.other)
                    report_mismatch($sformatf(
                        "status %0d/%0d owner %0d/%0d mark %b/%b other %b/%b (got/want)",
                        rsp_ch.status, want.status, rsp_ch.owner_core, want.owner,
                        rsp_ch.dangling_mark, want.mark, rsp_ch.other_core, want.other));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
            || (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            || (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.operation   = '0;
        req_ch.address     = '0;
        req_ch.core_id     = '0;
        req_ch.is_dangling = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.own_core_id = '0;
        rsp_ch.ready       = 1'b0;
        errors       = 0;
        quiet_cycles = 0;
        entry_cnt    = 0;
        own_id       = '0;
        req_idle_on  = 1'b1;
        rsp_idle_on  = 1'b1;
        rsp_hold_len = 0;

        // empty table, then extremes, hits, and the three insert clashes
        add_row(OP_LOOKUP_OWNER,  32'h0000_0000, 6'd0,  1'b0, 1'b1,
                '{ST_MISSING, 6'd0, 1'b0, 1'b0});
        add_row(OP_TEST_DANGLING, 32'hFFFF_FFFF, 6'd63, 1'b1, 1'b1,
                '{ST_MISSING, 6'd0, 1'b0, 1'b0});
        add_row(OP_QUERY_OTHER,   32'h1234_5678, 6'd9,  1'b0, 1'b1,
                '{ST_MISSING, 6'd0, 1'b0, 1'b0});
        add_row(OP_INSERT,        32'h0000_0000, 6'd0,  1'b0, 1'b1,
                '{ST_OK, 6'd0, 1'b0, 1'b0});
        add_row(OP_INSERT,        32'hFFFF_FFFF, 6'd63, 1'b1, 1'b1,
                '{ST_OK, 6'd63, 1'b1, 1'b0});
        add_row(OP_LOOKUP_OWNER,  32'h0000_0000, 6'd17, 1'b1, 1'b1,
                '{ST_OK, 6'd0, 1'b0, 1'b0});
        add_row(OP_QUERY_OTHER,   32'hFFFF_FFFF, 6'd0,  1'b0, 1'b1,
                '{ST_OK, 6'd63, 1'b1, 1'b1});
        add_row(OP_TEST_DANGLING, 32'hFFFF_FFFF, 6'd0,  1'b0, 1'b1,
                '{ST_OK, 6'd63, 1'b1, 1'b1});
        add_row(OP_INSERT,        32'hFFFF_FFFF, 6'd63, 1'b0, 1'b1,
                '{ST_SAME, 6'd63, 1'b1, 1'b0});
        add_row(OP_INSERT,        32'hFFFF_FFFF, 6'd5,  1'b0, 1'b1,
                '{ST_IGNORED, 6'd63, 1'b1, 1'b0});
        add_row(OP_INSERT,        32'hFFFF_FFFF, 6'd5,  1'b1, 1'b1,
                '{ST_CONFLICT, 6'd63, 1'b1, 1'b0});
        add_row(OP_INSERT,        32'h0000_0000, 6'd7,  1'b0, 1'b1,
                '{ST_CONFLICT, 6'd0, 1'b0, 1'b0});
        add_row(OP_INSERT,        32'h0000_0000, 6'd7,  1'b1, 1'b1,
                '{ST_CONFLICT, 6'd0, 1'b0, 1'b0});
        add_row(OP_INSERT,        32'h8000_0001, 6'd42, 1'b1, 1'b0, owner_reply_t'(0));
        add_row(OP_LOOKUP_OWNER,  32'h8000_0001, 6'd0,  1'b0, 1'b0, owner_reply_t'(0));
        add_row(OP_QUERY_OTHER,   32'h8000_0001, 6'd1,  1'b0, 1'b0, owner_reply_t'(0));
        add_row(OP_QUERY_OTHER,   32'h7FFF_FFFE, 6'd1,  1'b1, 1'b0, owner_reply_t'(0));
        add_row(OP_INSERT,        32'h5555_AAAA, 6'd21, 1'b0, 1'b0, owner_reply_t'(0));
        add_row(OP_TEST_DANGLING, 32'h5555_AAAA, 6'd0,  1'b0, 1'b0, owner_reply_t'(0));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].op, directed_rows[i].addr, directed_rows[i].core,
                         directed_rows[i].dang, directed_rows[i].typed, directed_rows[i].want);
        wait_drained();

        write_own_core(6'd63);
        repeat (150) random_request();
        wait_drained();

        // fill the table back to back, then run into the full case
        write_own_core(6'd0);
        req_idle_on = 1'b0;
        rsp_idle_on = 1'b0;
        while (entry_cnt < TABLE_DEPTH)
            send_request(OP_INSERT, $urandom, CORE_W'($urandom), 1'($urandom_range(0, 1)),
                         1'b0, owner_reply_t'(0));
        repeat (6)
            send_request(OP_INSERT, $urandom, CORE_W'($urandom), 1'($urandom_range(0, 1)),
                         1'b0, owner_reply_t'(0));
        wait_drained();

        // long response hold-off so the chain backs up into the request side
        write_own_core(CORE_W'($urandom));
        rsp_idle_on  = 1'b1;
        rsp_hold_len = 300;
        repeat (120) random_request();
        wait_drained();

        write_own_core(CORE_W'($urandom_range(1, 62)));
        req_idle_on = 1'b1;
        repeat (150) random_request();
        wait_drained();

        repeat (TABLE_DEPTH + 8) @(posedge clk);
        if (owed_replies.size() != 0)
            report_mismatch($sformatf("%0d responses never arrived", owed_replies.size()));
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
